FILE: hw/rtl/shbu_pkg.sv
// shared constants and the prime table of the smooth hash block update
`timescale 1ns / 1ps
package shbu_pkg;
  localparam int NUM_PRIMES = 43;
  localparam int MODULUS_BITS = 256;
  localparam int CNT_W = 9;
  localparam int IDX_W = 6;
  localparam int PRIME_W = 8;
  localparam int HASH_W = 64;
  localparam int TRUNC_W = 7;
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_TRUNC_LEN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_VALUE = 8'd1;
  localparam logic [MODULUS_BITS-1:0] MODULUS_N =
    256'hFFFFFFFFFFFFFFFF_FFFFFFFFFFFFFE4E_0000000000000000_000000000000AACD;

  function automatic logic [PRIME_W-1:0] prime_at(input logic [IDX_W-1:0] i);
    logic [PRIME_W-1:0] p;
    case (i)
      6'd0: p = 8'd2;     6'd1: p = 8'd3;     6'd2: p = 8'd5;     6'd3: p = 8'd7;
      6'd4: p = 8'd11;    6'd5: p = 8'd13;    6'd6: p = 8'd17;    6'd7: p = 8'd19;
      6'd8: p = 8'd23;    6'd9: p = 8'd29;    6'd10: p = 8'd31;   6'd11: p = 8'd37;
      6'd12: p = 8'd41;   6'd13: p = 8'd43;   6'd14: p = 8'd47;   6'd15: p = 8'd53;
      6'd16: p = 8'd59;   6'd17: p = 8'd61;   6'd18: p = 8'd67;   6'd19: p = 8'd71;
      6'd20: p = 8'd73;   6'd21: p = 8'd79;   6'd22: p = 8'd83;   6'd23: p = 8'd89;
      6'd24: p = 8'd97;   6'd25: p = 8'd101;  6'd26: p = 8'd103;  6'd27: p = 8'd107;
      6'd28: p = 8'd109;  6'd29: p = 8'd113;  6'd30: p = 8'd127;  6'd31: p = 8'd131;
      6'd32: p = 8'd137;  6'd33: p = 8'd139;  6'd34: p = 8'd149;  6'd35: p = 8'd151;
      6'd36: p = 8'd157;  6'd37: p = 8'd163;  6'd38: p = 8'd167;  6'd39: p = 8'd173;
      6'd40: p = 8'd179;  6'd41: p = 8'd181;  6'd42: p = 8'd191;
      default: p = 8'd0;
    endcase
    return p;
  endfunction
endpackage

FILE: hw/rtl/shbu_modmul.sv
// bit-serial modular multiplier, multiplier bits msb first, double then add
`timescale 1ns / 1ps
module shbu_modmul (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [shbu_pkg::MODULUS_BITS-1:0]  a_in,
  input  logic [shbu_pkg::MODULUS_BITS-1:0]  b_in,
  input  logic [shbu_pkg::CNT_W-1:0]         len,
  output logic                               done,
  output logic [shbu_pkg::MODULUS_BITS-1:0]  result
);
  localparam int W = shbu_pkg::MODULUS_BITS;

  logic [W-1:0] acc;
  logic [W-1:0] a;
  logic [W-1:0] b;
  logic [shbu_pkg::CNT_W-1:0] cnt;
  logic busy;
  logic phase;
  logic [W:0] sum;
  logic [W+1:0] diff;
  logic [W-1:0] acc_next;

  // one shared add and reduce: doubling in phase 0, conditional add in phase 1
  always_comb begin
    if (phase) begin
      sum = {1'b0, acc} + {1'b0, (b[W-1] ? a : {W{1'b0}})};
    end else begin
      sum = {1'b0, acc} + {1'b0, acc};
    end
    diff = {1'b0, sum} - {2'b00, shbu_pkg::MODULUS_N};
    acc_next = diff[W+1] ? sum[W-1:0] : diff[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      phase <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        phase <= 1'b0;
        acc <= '0;
        a <= a_in;
        b <= b_in;
        cnt <= len;
      end else if (busy) begin
        acc <= acc_next;
        phase <= ~phase;
        if (phase) begin
          b <= {b[W-2:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == shbu_pkg::CNT_W'(1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign result = acc;
endmodule

FILE: hw/rtl/smooth_hash_block_update.sv
// smooth hash block update: x <- x^2 * prod(selected primes) mod n, hash out on last block
// steps: square x, then scan the block bits and multiply by the prime of each set bit, all on one bit-serial multiplier
// flow: one block at a time; the next block is taken once the previous one is done
// reset: running value 1, trunc_len 64, match_value 0, no result pending
`timescale 1ns / 1ps
module smooth_hash_block_update (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // block_bits[42:0], zero fill
  input  logic         s_tlast,   // last_block
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // hash_top[63:0], truncated_hash[127:64], target_match[128]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  localparam int W = shbu_pkg::MODULUS_BITS;
  localparam int HW = shbu_pkg::HASH_W;

  typedef enum logic [2:0] {IDLE, SQ_START, SQ_WAIT, PR_SCAN, PR_WAIT, FINISH} state_t;

  state_t state;
  logic [W-1:0] x;
  logic [shbu_pkg::NUM_PRIMES-1:0] blk;
  logic lst;
  logic [shbu_pkg::IDX_W-1:0] idx;
  logic [shbu_pkg::TRUNC_W-1:0] trunc_len;
  logic [HW-1:0] match_value;
  logic mul_start;
  logic [W-1:0] mul_b;
  logic [shbu_pkg::CNT_W-1:0] mul_len;
  logic mul_done;
  logic [W-1:0] mul_res;
  logic [HW-1:0] top;
  logic [shbu_pkg::TRUNC_W-1:0] t_eff;
  logic [HW-1:0] tr;
  logic res_load;

  shbu_modmul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a_in(x), .b_in(mul_b),
    .len(mul_len), .done(mul_done), .result(mul_res)
  );

  always_comb begin
    top = x[W-1:W-HW];
    if (trunc_len == '0) begin
      t_eff = shbu_pkg::TRUNC_W'(1);
    end else if (trunc_len > shbu_pkg::TRUNC_W'(HW)) begin
      t_eff = shbu_pkg::TRUNC_W'(HW);
    end else begin
      t_eff = trunc_len;
    end
    tr = top >> (shbu_pkg::TRUNC_W'(HW) - t_eff);
  end

  assign s_tready = (state == IDLE);
  assign cfg_ready = 1'b1;
  assign res_load = (state == FINISH) && lst && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      x <= W'(1);
      trunc_len <= shbu_pkg::TRUNC_W'(HW);
      match_value <= '0;
      mul_start <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid) begin
        if (cfg_index == shbu_pkg::REG_TRUNC_LEN) begin
          trunc_len <= cfg_data[shbu_pkg::TRUNC_W-1:0];
        end else if (cfg_index == shbu_pkg::REG_MATCH_VALUE) begin
          match_value <= cfg_data;
        end
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            blk <= s_tdata[shbu_pkg::NUM_PRIMES-1:0];
            lst <= s_tlast;
            state <= SQ_START;
          end
        end
        SQ_START: begin
          mul_b <= x;
          mul_len <= shbu_pkg::CNT_W'(W);
          mul_start <= 1'b1;
          idx <= '0;
          state <= SQ_WAIT;
        end
        SQ_WAIT: begin
          if (mul_done) begin
            x <= mul_res;
            state <= PR_SCAN;
          end
        end
        PR_SCAN: begin
          if (idx == shbu_pkg::IDX_W'(shbu_pkg::NUM_PRIMES)) begin
            state <= FINISH;
          end else if (blk[idx]) begin
            // prime sits in the top byte so only its 8 bits are walked
            mul_b <= {shbu_pkg::prime_at(idx), {(W-shbu_pkg::PRIME_W){1'b0}}};
            mul_len <= shbu_pkg::CNT_W'(shbu_pkg::PRIME_W);
            mul_start <= 1'b1;
            state <= PR_WAIT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        PR_WAIT: begin
          if (mul_done) begin
            x <= mul_res;
            idx <= idx + 1'b1;
            state <= PR_SCAN;
          end
        end
        FINISH: begin
          if (!lst) begin
            state <= IDLE;
          end else if (res_load) begin
            m_tdata <= {7'd0, (tr == match_value), tr, top};
            x <= W'(1);
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

FILE: tb/tb_smooth_hash_block_update.sv
// testbench for the smooth hash block update: directed and random messages against a predictor
`timescale 1ns / 1ps
module tb_smooth_hash_block_update;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN_CYCLES = 1500;
  localparam logic [7:0] REG_UNKNOWN = 8'd9;

  typedef struct packed {
    logic          match;
    logic [63:0]   trunc;
    logic [63:0]   top;
  } hash_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  smooth_hash_block_update dut (.*);

  always #2 clk = ~clk;

  // predictor state
  logic [255:0] hash_state;
  logic [6:0]   trunc_reg;
  logic [63:0]  target_reg;
  hash_result_t expected_hashes[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  function automatic logic [255:0] mod_mult(input logic [255:0] a, input logic [255:0] b);
    logic [511:0] prod;
    prod = {256'd0, a} * {256'd0, b};
    return 256'(prod % {256'd0, shbu_pkg::MODULUS_N});
  endfunction

  task automatic predict_block(input logic [47:0] bits, input logic last);
    logic [63:0] top;
    int t;
    hash_result_t r;
    hash_state = mod_mult(hash_state, hash_state);
    for (int i = 0; i < shbu_pkg::NUM_PRIMES; i++)
      if (bits[i]) hash_state = mod_mult(hash_state, 256'(shbu_pkg::prime_at(6'(i))));
    if (last) begin
      top = hash_state[255:192];
      t = trunc_reg;
      if (t == 0) t = 1;
      if (t > 64) t = 64;
      r.top = top;
      r.trunc = (t == 64) ? top : (top >> (64 - t));
      r.match = (r.trunc == target_reg);
      expected_hashes = {expected_hashes, r};
      hash_state = 256'd1;
    end
  endtask

  // receiver stall pattern and result check
  always @(posedge clk) begin
    hash_result_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[128:0];
        if (expected_hashes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected hash result %h", got);
        end else begin
          want = expected_hashes.pop_front();
          if (got.top !== want.top || got.trunc !== want.trunc || got.match !== want.match) begin
            mismatches++;
            if (mismatches <= 10)
              $display("hash mismatch: exp top %h trunc %h match %b, got top %h trunc %h match %b",
                       want.top, want.trunc, want.match, got.top, got.trunc, got.match);
          end
        end
      end
      m_tready <= ($urandom_range(0, 7) < 5) || ($time % 40000 < 8000);
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else if (idle_cycles + 1 >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // registers change only once every pending hash has come out
  task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
    do @(posedge clk); while (expected_hashes.size() != 0);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == shbu_pkg::REG_TRUNC_LEN) trunc_reg = val[6:0];
    else if (idx == shbu_pkg::REG_MATCH_VALUE) target_reg = val;
  endtask

  task automatic send_block(input logic [47:0] bits, input logic last);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = $urandom_range(1, 6);
    end else begin
      @(posedge clk);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= bits;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    s_tvalid <= 1'b0;
    predict_block(bits, last);
  endtask

  task automatic wait_drained();
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_bits();
    return {5'd0, 11'($urandom), $urandom};
  endfunction

  task automatic test_field_extremes();
    send_block(48'd0, 1'b1);
    send_block({5'd0, {43{1'b1}}}, 1'b1);
    send_block(48'd1, 1'b0);
    send_block(48'h400_0000_0000, 1'b1);
    for (int i = 0; i < 6; i++) send_block({5'd0, {43{1'b1}}}, i == 5);
    send_block(48'd0, 1'b0);
    send_block(48'h555_5555_5555, 1'b0);
    send_block(48'h2AA_AAAA_AAAA, 1'b1);
    wait_drained();
  endtask

  task automatic test_truncation();
    write_reg(shbu_pkg::REG_TRUNC_LEN, 64'd0);    // zero acts as one bit
    send_block(rand_bits(), 1'b1);
    write_reg(shbu_pkg::REG_TRUNC_LEN, 64'd127);  // wide values clamp to 64
    send_block(rand_bits(), 1'b1);
    write_reg(shbu_pkg::REG_TRUNC_LEN, 64'd1);
    write_reg(shbu_pkg::REG_MATCH_VALUE, 64'd1);
    send_block(rand_bits(), 1'b1);
    send_block(rand_bits(), 1'b1);
    write_reg(shbu_pkg::REG_MATCH_VALUE, '1);
    write_reg(shbu_pkg::REG_TRUNC_LEN, 64'd65);
    write_reg(REG_UNKNOWN, 64'd3);       // ignored
    send_block(rand_bits(), 1'b1);
    wait_drained();
  endtask

  task automatic test_random_messages(input int n_blocks);
    int sent = 0;
    while (sent < n_blocks) begin
      int len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++) begin
        send_block(($urandom_range(0, 9) == 0)
                     ? (($urandom_range(0, 3) != 0) ? {5'd0, {43{1'b1}}} : 48'd0)
                     : rand_bits(), i == len - 1);
        sent++;
      end
      // reconfigure between some messages; the target is often a small value so that short truncations can match
      if ($urandom_range(0, 9) == 0) begin
        wait_drained();
        write_reg(shbu_pkg::REG_TRUNC_LEN, 64'($urandom_range(0, 127)));
        write_reg(shbu_pkg::REG_MATCH_VALUE, $urandom_range(0, 1) ? 64'($urandom_range(0, 3))
                                                                  : {$urandom, $urandom});
      end
    end
    send_block(rand_bits(), 1'b1);
    wait_drained();
  endtask

  initial begin
    hash_state = 256'd1;
    trunc_reg = 7'd64;
    target_reg = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_truncation();
    test_random_messages(1000);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
